// ===== rtl/table_linear_interpolator_assert.svh =====
// Assertion macros for the interpolator RTL.
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tli_pkg.sv =====
`timescale 1ns / 1ps

package tli_pkg;

  // Data widths of the Q16.16 words and of the interpolation product.
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W);

  // Command codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_TOO_FEW  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } tli_state_t;

endpackage

// ===== rtl/tli_if.sv =====
`timescale 1ns / 1ps

// Command channel: one beat carries one command with its point or query x.
interface tli_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;

  modport source (output valid, output command, output x_value, output y_value, input ready);
  modport sink   (input valid, input command, input x_value, input y_value, output ready);
endinterface

// Result channel: one beat per command.
interface tli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_result;
  logic [1:0]         status;
  logic               exact_hit;

  modport source (output valid, output y_result, output status, output exact_hit, input ready);
  modport sink   (input valid, input y_result, input status, input exact_hit, output ready);
endinterface

// ===== rtl/table_linear_interpolator.sv =====
// Piecewise linear interpolation table.
// Commands arrive on in_ch (valid/ready); each produces exactly one beat on
// out_ch. Clear empties the table, append stores one (x, y) point, query
// returns, for an x strictly between the smallest and largest stored x, the
// exact y of a matching x or the interpolated y between the nearest stored
// neighbours, with status for out-of-range, too few points or a full table.
// Clear, append, the ignored code and a query on fewer than two points go
// from idle straight to the output state, which loads the output register.
// A query on N >= 2 points reads one stored point per cycle; an exact hit or
// an out-of-range x then goes to the output state. An interpolated query
// passes through a multiply state and a 64-step bit-serial divider before
// it reaches the output state.
// A new command is accepted only once the sequencer is idle again, so a
// command is never taken before the previous one has left the output state.
// The result sits in an output register; the next command is taken while it
// waits, and the sequencer holds its next result until out_ch.ready frees the
// register. Reset empties the table and drops any pending result; the point
// memory itself keeps its contents.
`timescale 1ns / 1ps
`include "table_linear_interpolator_assert.svh"

module table_linear_interpolator #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  tli_in_if.sink    in_ch,
  tli_out_if.source out_ch
);
  import tli_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tli_state_t state_r, state_nxt;

  // Point memory: x in the upper half, y in the lower.
  logic [PROD_W-1:0] mem [DEPTH];
  logic [PROD_W-1:0] rd_data_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] issue_cnt_r;
  logic          rd_vld_r;
  logic          start_r;
  logic          out_valid_r;

  logic signed [DATA_W-1:0] qx_r, lo_r, hi_r, xa_r, ya_r, xb_r, yb_r, hit_y_r;
  logic                     first_r, hit_r, have_a_r, have_b_r;
  logic [DATA_W-1:0]        mag_r, dx_r, den_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        prod_r;

  logic signed [DATA_W-1:0] res_y_r, out_y_r;
  logic [1:0]               res_status_r, out_status_r;
  logic                     res_hit_r, out_hit_r;

  logic                     in_fire, full, wr_en, scan_issue, scan_end, in_range, out_load;
  logic signed [DATA_W-1:0] v, yv;
  logic signed [DATA_W:0]   dy, dx, den;
  logic [DATA_W:0]          dy_mag;
  logic                     div_done;
  logic [DATA_W-1:0]        div_q;

  // Handshake and sequencing conditions.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(DEPTH));
  assign wr_en       = in_fire && (in_ch.command == CMD_APPEND) && !full;
  assign scan_issue  = (state_r == S_SCAN) && (issue_cnt_r < count_r);
  assign scan_end    = (state_r == S_SCAN) && !scan_issue && !rd_vld_r;
  assign in_range    = (qx_r > lo_r) && (qx_r < hi_r);
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Fields of the point just read.
  assign v  = rd_data_r[PROD_W-1:DATA_W];
  assign yv = rd_data_r[DATA_W-1:0];

  // Interpolation operands from the two neighbours.
  assign dy     = {yb_r[DATA_W-1], yb_r} - {ya_r[DATA_W-1], ya_r};
  assign dx     = {qx_r[DATA_W-1], qx_r} - {xa_r[DATA_W-1], xa_r};
  assign den    = {xb_r[DATA_W-1], xb_r} - {xa_r[DATA_W-1], xa_r};
  assign dy_mag = dy[DATA_W] ? (~dy + 1'b1) : dy;

  // Point memory: written on append, read once per point during a scan.
  // Writes happen only in idle, so they never meet a scan read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= {in_ch.x_value, in_ch.y_value};
    end
    if (scan_issue) begin
      rd_data_r <= mem[issue_cnt_r[AW-1:0]];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_ch.command == CMD_QUERY) && (count_r >= CW'(2))) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = (in_range && !hit_r) ? S_MUL : S_OUT;
        end
      end
      S_MUL: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= scan_issue;
      start_r  <= (state_r == S_MUL);
      if (in_fire && (in_ch.command == CMD_CLEAR)) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
      if (in_fire) begin
        issue_cnt_r <= '0;
      end else if (scan_issue) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: command decode, scan, operand set-up and result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      qx_r      <= in_ch.x_value;
      first_r   <= 1'b1;
      hit_r     <= 1'b0;
      have_a_r  <= 1'b0;
      have_b_r  <= 1'b0;
      res_y_r   <= '0;
      res_hit_r <= 1'b0;
      case (in_ch.command)
        CMD_APPEND: res_status_r <= full ? ST_FULL : ST_OK;
        CMD_QUERY:  res_status_r <= (count_r < CW'(2)) ? ST_TOO_FEW : ST_OK;
        default:    res_status_r <= ST_OK;
      endcase
    end

    // One stored point per beat: bounds, first exact match, neighbours.
    if (rd_vld_r) begin
      first_r <= 1'b0;
      if (first_r || (v < lo_r)) begin
        lo_r <= v;
      end
      if (first_r || (v > hi_r)) begin
        hi_r <= v;
      end
      if (!hit_r && (v == qx_r)) begin
        hit_r   <= 1'b1;
        hit_y_r <= yv;
      end
      if ((v < qx_r) && (!have_a_r || (v > xa_r))) begin
        have_a_r <= 1'b1;
        xa_r     <= v;
        ya_r     <= yv;
      end
      if ((v > qx_r) && (!have_b_r || (v < xb_r))) begin
        have_b_r <= 1'b1;
        xb_r     <= v;
        yb_r     <= yv;
      end
    end

    // End of scan: decide the outcome and latch the divider operands.
    if (scan_end) begin
      if (!in_range) begin
        res_status_r <= ST_OUTSIDE;
      end else if (hit_r) begin
        res_y_r   <= hit_y_r;
        res_hit_r <= 1'b1;
      end
      mag_r <= dy_mag[DATA_W-1:0];
      neg_r <= dy[DATA_W];
      dx_r  <= dx[DATA_W-1:0];
      den_r <= den[DATA_W-1:0];
    end

    if (state_r == S_MUL) begin
      prod_r <= mag_r * dx_r;
    end

    if (div_done) begin
      res_y_r <= neg_r ? (ya_r - $signed(div_q)) : (ya_r + $signed(div_q));
    end

    if (out_load) begin
      out_y_r      <= res_y_r;
      out_status_r <= res_status_r;
      out_hit_r    <= res_hit_r;
    end
  end

  // Divider for the slope term.
  tli_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (prod_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.y_result  = out_y_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.exact_hit = out_hit_r;

  // Checks on the sequencer.
  `TLI_ASSERT_IMP(a_hit_ok, clk, rst_n, out_ch.valid && out_ch.exact_hit, out_ch.status == ST_OK, "exact hit with bad status")
  `TLI_ASSERT_IMP(a_div_state, clk, rst_n, div_done, state_r == S_DIV, "divider finished outside the divide state")
  `TLI_ASSERT_IMP(a_read_scan, clk, rst_n, rd_vld_r, state_r == S_SCAN, "read data outside a scan")
  `TLI_ASSERT_NXT(a_append_count, clk, rst_n, wr_en, count_r == $past(count_r) + 1'b1, "append did not advance the count")

endmodule

// ===== rtl/tli_divider.sv =====
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// known to fit the data width, so only its low half is returned.
module tli_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tli_pkg::PROD_W-1:0]    dividend,
  input  logic [tli_pkg::DATA_W-1:0]    divisor,
  output logic                          done,
  output logic [tli_pkg::DATA_W-1:0]    quotient
);
  import tli_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    divisor_r;
  logic [PROD_W-1:0]    quo_r;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 take;

  // One step: bring down the next dividend bit and try the subtraction.
  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign diff    = shifted - {1'b0, divisor_r};
  assign take    = (shifted >= {1'b0, divisor_r});

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      divisor_r <= divisor;
      quo_r     <= dividend;
    end else if (busy_r) begin
      rem_r <= take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[DATA_W-1:0];

endmodule
